// File: design/rv32m_multiply_divide_unit_defines.svh
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_unit_defines.svh
// Assertion macros shared by the multiply/divide unit.
// ----------------------------------------------------------------------------
`ifndef RV32M_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH
`define RV32M_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define MDU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MDU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MDU_ASSERT(lbl, clk, rst_n, prop)
`define MDU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/mdu_pkg.sv
// ----------------------------------------------------------------------------
// mdu_pkg
// Types and constants of the RV32M multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mdu_pkg;
    localparam int XLEN     = 32;
    localparam int DIVSTEPS = XLEN;
    // Stage 0 is the operand stage, then one stage per quotient bit, then
    // the stage that fixes signs and special cases.
    localparam int NSTG     = DIVSTEPS + 2;
    localparam int HALF     = XLEN / 2;

    typedef enum logic [2:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_action;

    typedef struct packed {
        logic is_mul;
        logic hi;
        logic rem_sel;
        logic neg_q;   // negate product or quotient
        logic neg_r;
        logic div0;
    } t_ctl;

    typedef struct packed {
        t_ctl            ctl;
        logic [XLEN-1:0] a_mag;
        logic [XLEN-1:0] b_mag;
    } t_item;
endpackage
`default_nettype wire

// File: design/mdu_front.sv
// ----------------------------------------------------------------------------
// mdu_front
// Decodes the operation and turns signed operands into magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none
module mdu_front (
    input  wire logic [2:0]              i_action,
    input  wire logic [mdu_pkg::XLEN-1:0] i_operand_a,
    input  wire logic [mdu_pkg::XLEN-1:0] i_operand_b,
    output mdu_pkg::t_item                o_item
);
    import mdu_pkg::*;

    logic sa, sb, a_neg, b_neg;
    t_action op;

    assign op = t_action'(i_action);

    always_comb begin
        sa = 1'b0;
        sb = 1'b0;
        unique case (op)
            OP_MULH, OP_DIV, OP_REM: begin
                sa = 1'b1;
                sb = 1'b1;
            end
            OP_MULHSU: begin
                sa = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign a_neg = sa & i_operand_a[XLEN-1];
    assign b_neg = sb & i_operand_b[XLEN-1];

    assign o_item.a_mag       = a_neg ? (~i_operand_a + 1'b1) : i_operand_a;
    assign o_item.b_mag       = b_neg ? (~i_operand_b + 1'b1) : i_operand_b;
    assign o_item.ctl.is_mul  = ~i_action[2];
    assign o_item.ctl.hi      = (op != OP_MUL);
    assign o_item.ctl.rem_sel = i_action[1];
    assign o_item.ctl.neg_q   = a_neg ^ b_neg;
    assign o_item.ctl.neg_r   = a_neg;
    assign o_item.ctl.div0    = (i_operand_b == '0);
endmodule
`default_nettype wire

// File: design/mdu_queue.sv
// ----------------------------------------------------------------------------
// mdu_queue
// Two-entry queue between the decode front and the execution pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module mdu_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire mdu_pkg::t_item i_item,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_nonempty,
    output mdu_pkg::t_item o_item
);
    import mdu_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_item     = r_mem[r_rp];
endmodule
`default_nettype wire

// File: design/mdu_back.sv
// ----------------------------------------------------------------------------
// mdu_back
// Execution pipeline: a split multiplier and a one-bit-per-stage divider
// of equal depth, so results leave in order.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv32m_multiply_divide_unit_defines.svh"
module mdu_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_avail,
    input  wire mdu_pkg::t_item           i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [mdu_pkg::XLEN-1:0]      o_result_value
);
    import mdu_pkg::*;

    logic [NSTG-1:0] r_v;
    t_ctl            r_ctl  [NSTG-1];
    logic [XLEN-1:0] r_rem  [NSTG-1];
    logic [XLEN-1:0] r_quo  [NSTG-1];
    logic [XLEN-1:0] r_div  [NSTG-2];
    logic [XLEN-1:0] n_rem  [NSTG-1];
    logic [XLEN-1:0] n_quo  [NSTG-1];
    logic [XLEN-1:0] r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [2*XLEN-1:0] r_prod, n_prod, n_sprod;
    logic [XLEN-1:0] r_mres [3:NSTG-2];
    logic [XLEN-1:0] r_out, n_out, n_q, n_r;
    logic            adv;

    assign adv   = ~r_v[NSTG-1] | ~i_stall;
    assign o_pop = adv & i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NSTG-2:0], i_avail};
        end
    end

    // One restoring step per stage: shift in the next dividend bit and
    // subtract the divisor when it fits.
    for (genvar k = 1; k < NSTG - 1; k++) begin : g_step
        logic [XLEN:0] t, d;
        assign t = {r_rem[k-1], r_quo[k-1][XLEN-1]};
        assign d = t - {1'b0, r_div[k-1]};
        assign n_rem[k] = d[XLEN] ? t[XLEN-1:0] : d[XLEN-1:0];
        assign n_quo[k] = {r_quo[k-1][XLEN-2:0], ~d[XLEN]};
    end
    assign n_rem[0] = '0;
    assign n_quo[0] = i_item.a_mag;

    assign n_prod  = {r_pp_hh, r_pp_ll}
                   + {{HALF{1'b0}}, r_pp_lh, {HALF{1'b0}}}
                   + {{HALF{1'b0}}, r_pp_hl, {HALF{1'b0}}};
    assign n_sprod = r_ctl[2].neg_q ? (~r_prod + 1'b1) : r_prod;

    assign n_q = r_ctl[NSTG-2].div0 ? '1 :
                 (r_ctl[NSTG-2].neg_q ? (~r_quo[NSTG-2] + 1'b1) : r_quo[NSTG-2]);
    assign n_r = r_ctl[NSTG-2].neg_r ? (~r_rem[NSTG-2] + 1'b1) : r_rem[NSTG-2];

    always_comb begin
        priority if (r_ctl[NSTG-2].is_mul) begin
            n_out = r_mres[NSTG-2];
        end else if (r_ctl[NSTG-2].rem_sel) begin
            n_out = n_r;
        end else begin
            n_out = n_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ctl[0] <= i_item.ctl;
            r_div[0] <= i_item.b_mag;
            for (int k = 1; k < NSTG - 1; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            for (int k = 0; k < NSTG - 1; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 1; k < NSTG - 2; k++) begin
                r_div[k] <= r_div[k-1];
            end
            r_pp_ll <= r_quo[0][HALF-1:0]    * r_div[0][HALF-1:0];
            r_pp_lh <= r_quo[0][HALF-1:0]    * r_div[0][XLEN-1:HALF];
            r_pp_hl <= r_quo[0][XLEN-1:HALF] * r_div[0][HALF-1:0];
            r_pp_hh <= r_quo[0][XLEN-1:HALF] * r_div[0][XLEN-1:HALF];
            r_prod  <= n_prod;
            r_mres[3] <= r_ctl[2].hi ? n_sprod[2*XLEN-1:XLEN] : n_sprod[XLEN-1:0];
            for (int k = 4; k < NSTG - 1; k++) begin
                r_mres[k] <= r_mres[k-1];
            end
            r_out <= n_out;
        end
    end

    assign o_valid        = r_v[NSTG-1];
    assign o_result_value = r_out;

    `MDU_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(r_v))
    `MDU_ASSERT(a_entry_moves, i_clk, i_rst_n, (r_v[0] && adv) |=> r_v[1])
    `MDU_ASSERT(a_pop_needs_item, i_clk, i_rst_n, o_pop |-> i_avail)
    `MDU_ASSERT(a_div0_quot, i_clk, i_rst_n,
        (adv && r_v[NSTG-2] && !r_ctl[NSTG-2].is_mul && !r_ctl[NSTG-2].rem_sel
         && r_ctl[NSTG-2].div0) |=> (o_result_value == '1))
endmodule
`default_nettype wire

// File: design/rv32m_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_unit
// RV32M multiply/divide unit: decode front, two-entry queue, pipelined back.
// ----------------------------------------------------------------------------
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+-------------------------------------
//   input    | i_valid  | o_stall  | i_action, i_operand_a, i_operand_b
//   output   | o_valid  | i_stall  | o_result_value
//
// One beat per cycle is sustained while the output is not stalled; an accepted
// beat passes the queue, then the operand stage, the divider steps and the sign stage.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset is synchronous and clears only the queue pointers, the queue count and the stage valid bits.
// An output stall while a result is valid freezes the back pipeline; the queue takes up to two beats.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32m_multiply_divide_unit (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [2:0]              i_action,
    input  wire logic [mdu_pkg::XLEN-1:0] i_operand_a,
    input  wire logic [mdu_pkg::XLEN-1:0] i_operand_b,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [mdu_pkg::XLEN-1:0]     o_result_value
);
    import mdu_pkg::*;

    t_item dec_item, q_item;
    logic  q_full, q_nonempty, pop;

    mdu_front u_front (
        .i_action    (i_action),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_item      (dec_item)
    );

    assign o_stall = q_full;

    mdu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid & ~q_full),
        .i_item     (dec_item),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_item     (q_item)
    );

    mdu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_nonempty),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value)
    );
endmodule
`default_nettype wire
